/* hdl/dri_pkg.sv */
// shared types, constants and codes of the dead reckoning integrator
`default_nettype none
package dri_pkg;

   localparam int AXES = 3;
   localparam int ROOT_STEPS = 16;
   localparam int COUNT_W = 5;

   localparam logic [17:0] ENERGY_SCALE = 18'd37877;
   localparam logic [15:0] ERROR_TO_CM = 16'd100;

   localparam logic [15:0] ACCEL_GAIN_RESET = 16'd802;
   localparam logic [15:0] LOCATION_GAIN_RESET = 16'd262;
   localparam logic [15:0] FILTER_GAIN_RESET = 16'd655;
   localparam logic [15:0] INVERSE_TAU_RESET = 16'd26214;
   localparam logic [14:0] CORRECTION_PERIOD_RESET = 15'd14;

   typedef enum logic [2:0] {
      CSR_ACCEL_GAIN = 3'd0,
      CSR_LOCATION_GAIN = 3'd1,
      CSR_FILTER_GAIN = 3'd2,
      CSR_INVERSE_TAU = 3'd3,
      CSR_CORRECTION_PERIOD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic operation;
      logic enabled;
      logic gps_valid;
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
      logic signed [15:0] heading_a;
      logic signed [15:0] heading_b;
   } req_type;

   typedef struct packed {
      logic signed [15:0] velocity_x;
      logic signed [15:0] velocity_y;
      logic signed [15:0] velocity_z;
      logic signed [15:0] location_x;
      logic signed [15:0] location_y;
      logic signed [15:0] location_z;
      logic signed [15:0] forward_speed;
      logic [15:0] air_speed;
      logic signed [15:0] energy_sum;
      logic drift_reset;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_AI = 4'd0,
      OP_PS = 4'd1,
      OP_CV = 4'd2,
      OP_CL = 4'd3,
      OP_VL = 4'd4,
      OP_UPD = 4'd5,
      OP_CLR = 4'd6,
      OP_AIR = 4'd7,
      OP_FS1 = 4'd8,
      OP_FS2 = 4'd9,
      OP_SQ = 4'd10,
      OP_SC = 4'd11,
      OP_EN = 4'd12
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_APPLY = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic take_in;
      logic exec;
      logic apply;
      op_type op;
      logic [1:0] axis;
      logic root_load;
      logic root_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic countdown_nz;
   } status_type;

endpackage
`default_nettype wire

/* hdl/dead_reckoning_integrator_unit.sv */
// dead reckoning integrator top level: sequencer plus datapath
// gps fix transfer: stored on acceptance, gives no result, input stays ready
// tick: result via the op list (13, 19 or 25 steps: disabled, enabled without, with correction),
// each step an exec then an apply state, then the root load, ROOT_STEPS root steps and the output load
// one item at a time: no request is taken until the result is loaded, and the done state waits on rsp stall
// reset: synchronous active high, config to defaults, integrators and errors cleared
`default_nettype none
module dead_reckoning_integrator_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire dri_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output dri_pkg::rsp_type rsp_data,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data
);

   // command and status between the sequencer and the datapath
   dri_pkg::cmd_type cmd;
   dri_pkg::status_type status;

   // sequencer: walks the product list, runs the root, holds rsp_valid
   dri_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_operation(req_data.operation),
      .req_enabled(req_data.enabled),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status(status),
      .cmd(cmd)
   );

   // datapath: config registers, integrators, errors, output register
   dri_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cmd(cmd),
      .status(status),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

/* hdl/dri_ctrl.sv */
// sequencer for the integrator datapath
`default_nettype none
module dri_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_operation,
   input wire logic req_enabled,
   output logic req_stall,
   output logic rsp_valid,
   input wire logic rsp_stall,
   input wire dri_pkg::status_type status,
   output dri_pkg::cmd_type cmd
);

   dri_pkg::state_type state_ff, state_in;
   dri_pkg::op_type op_ff, op_in;
   logic [1:0] axis_ff, axis_in;
   logic [dri_pkg::COUNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign accept = req_valid && (state_ff == dri_pkg::ST_IDLE);
   assign req_stall = (state_ff != dri_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      axis_in = axis_ff;
      count_in = count_ff;
      cmd = '0;
      cmd.take_in = accept;
      cmd.op = op_ff;
      cmd.axis = axis_ff;
      unique case (state_ff)
         dri_pkg::ST_IDLE: begin
            if (accept && !req_operation) begin
               state_in = dri_pkg::ST_EXEC;
               op_in = req_enabled ? dri_pkg::OP_AI : dri_pkg::OP_CLR;
               axis_in = 2'd0;
            end
         end
         dri_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = dri_pkg::ST_APPLY;
         end
         dri_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in = dri_pkg::ST_EXEC;
            unique case (op_ff)
               dri_pkg::OP_AI: begin
                  if (axis_ff != 2'd2) axis_in = axis_ff + 2'd1;
                  else begin
                     op_in = dri_pkg::OP_PS;
                     axis_in = 2'd0;
                  end
               end
               dri_pkg::OP_PS: begin
                  if (axis_ff != 2'd2) axis_in = axis_ff + 2'd1;
                  else if (status.countdown_nz) begin
                     op_in = dri_pkg::OP_CV;
                     axis_in = 2'd0;
                  end else op_in = dri_pkg::OP_UPD;
               end
               dri_pkg::OP_CV: op_in = dri_pkg::OP_CL;
               dri_pkg::OP_CL: op_in = dri_pkg::OP_VL;
               dri_pkg::OP_VL: begin
                  if (axis_ff == 2'd0) begin
                     op_in = dri_pkg::OP_CV;
                     axis_in = 2'd1;
                  end else op_in = dri_pkg::OP_UPD;
               end
               dri_pkg::OP_UPD: op_in = dri_pkg::OP_AIR;
               dri_pkg::OP_CLR: op_in = dri_pkg::OP_AIR;
               dri_pkg::OP_AIR: op_in = dri_pkg::OP_FS1;
               dri_pkg::OP_FS1: op_in = dri_pkg::OP_FS2;
               dri_pkg::OP_FS2: begin
                  op_in = dri_pkg::OP_SQ;
                  axis_in = 2'd0;
               end
               dri_pkg::OP_SQ: begin
                  if (axis_ff != 2'd2) axis_in = axis_ff + 2'd1;
                  else begin
                     op_in = dri_pkg::OP_SC;
                     axis_in = 2'd0;
                  end
               end
               dri_pkg::OP_SC: op_in = dri_pkg::OP_EN;
               dri_pkg::OP_EN: begin
                  if (axis_ff != 2'd2) begin
                     op_in = dri_pkg::OP_SC;
                     axis_in = axis_ff + 2'd1;
                  end else begin
                     state_in = dri_pkg::ST_ROOT;
                     count_in = '0;
                  end
               end
               default: state_in = dri_pkg::ST_IDLE;
            endcase
         end
         dri_pkg::ST_ROOT: begin
            if (count_ff == '0) cmd.root_load = 1'b1;
            else cmd.root_step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == dri_pkg::COUNT_W'(dri_pkg::ROOT_STEPS))
               state_in = dri_pkg::ST_DONE;
         end
         dri_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in = dri_pkg::ST_IDLE;
            end
         end
         default: state_in = dri_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dri_pkg::ST_IDLE;
         op_ff <= dri_pkg::OP_AI;
         axis_ff <= 2'd0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         axis_ff <= axis_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/dri_dp.sv */
// integrator datapath: state, config, shared multiplier, square root
`default_nettype none
module dri_dp (
   input wire logic clock,
   input wire logic reset,
   input wire dri_pkg::req_type req_data,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data,
   input wire dri_pkg::cmd_type cmd,
   output dri_pkg::status_type status,
   output dri_pkg::rsp_type rsp_data
);

   logic [15:0] ag_ff, lg_ff, fg_ff, it_ff;
   logic [14:0] period_ff;

   logic [31:0] ai_ff [dri_pkg::AXES], ai_in [dri_pkg::AXES];
   logic [31:0] ps_ff [dri_pkg::AXES], ps_in [dri_pkg::AXES];
   logic [15:0] le_ff [dri_pkg::AXES], le_in [dri_pkg::AXES];
   logic [15:0] ve_ff [dri_pkg::AXES], ve_in [dri_pkg::AXES];
   logic [15:0] fixl_ff [dri_pkg::AXES], fixl_in [dri_pkg::AXES];
   logic [15:0] fixv_ff [dri_pkg::AXES], fixv_in [dri_pkg::AXES];
   logic [15:0] cd_ff, cd_in;
   logic pend_ff, pend_in;

   logic [31:0] vel_ff [dri_pkg::AXES], vel_in [dri_pkg::AXES];
   logic [15:0] air_ff [dri_pkg::AXES], air_in [dri_pkg::AXES];
   logic [15:0] h_ff, h_in;
   logic [31:0] acc_ff, acc_in, sumsq_ff, sumsq_in, energy_ff, energy_in;
   logic drift_ff, drift_in;
   logic [31:0] prod_ff;
   logic [31:0] rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   dri_pkg::req_type in_ff;
   dri_pkg::rsp_type out_ff;

   logic [15:0] wind [dri_pkg::AXES];
   logic [15:0] accel [dri_pkg::AXES];
   logic [15:0] le100;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] mul_p;
   logic [31:0] shifted;
   logic [32:0] trial;

   assign accel[0] = in_ff.first_x;
   assign accel[1] = in_ff.first_y;
   assign accel[2] = in_ff.first_z;
   assign wind[0] = in_ff.second_x;
   assign wind[1] = in_ff.second_y;
   assign wind[2] = in_ff.second_z;

   assign status.countdown_nz = (cd_ff != 16'd0);
   assign rsp_data = out_ff;

   // operand select for the shared multiplier
   assign le100 = 16'(le_ff[cmd.axis] * dri_pkg::ERROR_TO_CM);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         dri_pkg::OP_AI: begin
            mul_a = 18'(signed'(ag_ff));
            mul_b = 18'(signed'(accel[cmd.axis]));
         end
         dri_pkg::OP_PS: begin
            mul_a = 18'(signed'(lg_ff));
            mul_b = 18'(signed'(ai_ff[cmd.axis][31:16]));
         end
         dri_pkg::OP_CV: begin
            mul_a = 18'(signed'(fg_ff));
            mul_b = 18'(signed'(ve_ff[cmd.axis]));
         end
         dri_pkg::OP_CL: begin
            mul_a = 18'(signed'(fg_ff));
            mul_b = 18'(signed'(le_ff[cmd.axis]));
         end
         dri_pkg::OP_VL: begin
            mul_a = signed'({2'b00, it_ff});
            mul_b = 18'(signed'(le100));
         end
         dri_pkg::OP_FS1: begin
            mul_a = 18'(signed'(16'(~ai_ff[0][31:16] + 16'd1)));
            mul_b = 18'(signed'(in_ff.heading_a));
         end
         dri_pkg::OP_FS2: begin
            mul_a = 18'(signed'(ai_ff[1][31:16]));
            mul_b = 18'(signed'(in_ff.heading_b));
         end
         dri_pkg::OP_SQ: begin
            mul_a = 18'(signed'(air_ff[cmd.axis]));
            mul_b = 18'(signed'(air_ff[cmd.axis]));
         end
         dri_pkg::OP_SC: begin
            mul_a = 18'(signed'(air_ff[cmd.axis]));
            mul_b = signed'(dri_pkg::ENERGY_SCALE);
         end
         dri_pkg::OP_EN: begin
            mul_a = 18'(signed'(h_ff));
            mul_b = 18'(signed'(h_ff));
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign shifted = {{4{prod_ff[31]}}, prod_ff[31:4]};
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   always_comb begin
      ai_in = ai_ff;
      ps_in = ps_ff;
      le_in = le_ff;
      ve_in = ve_ff;
      fixl_in = fixl_ff;
      fixv_in = fixv_ff;
      cd_in = cd_ff;
      pend_in = pend_ff;
      vel_in = vel_ff;
      air_in = air_ff;
      h_in = h_ff;
      acc_in = acc_ff;
      sumsq_in = sumsq_ff;
      energy_in = energy_ff;
      drift_in = drift_ff;
      if (cmd.take_in && req_data.operation) begin
         fixl_in[0] = req_data.first_x;
         fixl_in[1] = req_data.first_y;
         fixl_in[2] = req_data.first_z;
         fixv_in[0] = req_data.second_x;
         fixv_in[1] = req_data.second_y;
         fixv_in[2] = req_data.second_z;
         pend_in = 1'b1;
      end
      if (cmd.apply) begin
         unique case (cmd.op)
            dri_pkg::OP_AI: ai_in[cmd.axis] = ai_ff[cmd.axis] + prod_ff;
            dri_pkg::OP_PS: ps_in[cmd.axis] = ps_ff[cmd.axis] + shifted;
            dri_pkg::OP_CV: ai_in[cmd.axis] = ai_ff[cmd.axis] + prod_ff;
            dri_pkg::OP_CL: ps_in[cmd.axis] = ps_ff[cmd.axis] + prod_ff;
            dri_pkg::OP_VL: vel_in[cmd.axis] = ai_ff[cmd.axis] + prod_ff;
            dri_pkg::OP_UPD: begin
               vel_in[2] = ai_ff[2];
               if (!status.countdown_nz) begin
                  vel_in[0] = ai_ff[0];
                  vel_in[1] = ai_ff[1];
               end else cd_in = cd_ff - 16'd1;
               drift_in = !status.countdown_nz;
               if (in_ff.gps_valid && pend_ff) begin
                  pend_in = 1'b0;
                  cd_in = {1'b0, period_ff};
                  for (int k = 0; k < dri_pkg::AXES; k++) begin
                     le_in[k] = fixl_ff[k] - ps_ff[k][31:16];
                     ve_in[k] = fixv_ff[k] - ai_ff[k][31:16];
                  end
               end
            end
            dri_pkg::OP_CLR: begin
               for (int k = 0; k < dri_pkg::AXES; k++) begin
                  ai_in[k] = '0;
                  ps_in[k] = '0;
                  vel_in[k] = '0;
               end
               drift_in = 1'b0;
            end
            dri_pkg::OP_AIR: begin
               for (int k = 0; k < dri_pkg::AXES; k++)
                  air_in[k] = vel_ff[k][31:16] - wind[k];
               sumsq_in = '0;
               energy_in = ps_ff[2];
            end
            dri_pkg::OP_FS1: acc_in = prod_ff;
            dri_pkg::OP_FS2: acc_in = acc_ff + prod_ff;
            dri_pkg::OP_SQ: sumsq_in = sumsq_ff + prod_ff;
            dri_pkg::OP_SC: h_in = prod_ff[31:16];
            dri_pkg::OP_EN: energy_in = energy_ff + prod_ff;
            default: ;
         endcase
      end
   end

   // one result bit per step of the square root
   always_comb begin
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      if (cmd.root_load) begin
         rem_in = sumsq_ff;
         root_in = '0;
         bit_in = 32'h4000_0000;
      end else if (cmd.root_step) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[31:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else root_in = root_ff >> 1;
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ag_ff <= dri_pkg::ACCEL_GAIN_RESET;
         lg_ff <= dri_pkg::LOCATION_GAIN_RESET;
         fg_ff <= dri_pkg::FILTER_GAIN_RESET;
         it_ff <= dri_pkg::INVERSE_TAU_RESET;
         period_ff <= dri_pkg::CORRECTION_PERIOD_RESET;
         for (int k = 0; k < dri_pkg::AXES; k++) begin
            ai_ff[k] <= '0;
            ps_ff[k] <= '0;
            le_ff[k] <= '0;
            ve_ff[k] <= '0;
            fixl_ff[k] <= '0;
            fixv_ff[k] <= '0;
         end
         cd_ff <= {1'b0, dri_pkg::CORRECTION_PERIOD_RESET};
         pend_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               dri_pkg::CSR_ACCEL_GAIN: ag_ff <= csr_data;
               dri_pkg::CSR_LOCATION_GAIN: lg_ff <= csr_data;
               dri_pkg::CSR_FILTER_GAIN: fg_ff <= csr_data;
               dri_pkg::CSR_INVERSE_TAU: it_ff <= csr_data;
               dri_pkg::CSR_CORRECTION_PERIOD: period_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         ai_ff <= ai_in;
         ps_ff <= ps_in;
         le_ff <= le_in;
         ve_ff <= ve_in;
         fixl_ff <= fixl_in;
         fixv_ff <= fixv_in;
         cd_ff <= cd_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_in) in_ff <= req_data;
      if (cmd.exec) prod_ff <= mul_p[31:0];
      vel_ff <= vel_in;
      air_ff <= air_in;
      h_ff <= h_in;
      acc_ff <= acc_in;
      sumsq_ff <= sumsq_in;
      energy_ff <= energy_in;
      drift_ff <= drift_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      if (cmd.out_load) begin
         out_ff.velocity_x <= vel_ff[0][31:16];
         out_ff.velocity_y <= vel_ff[1][31:16];
         out_ff.velocity_z <= vel_ff[2][31:16];
         out_ff.location_x <= ps_ff[0][31:16];
         out_ff.location_y <= ps_ff[1][31:16];
         out_ff.location_z <= ps_ff[2][31:16];
         out_ff.forward_speed <= acc_ff[29:14];
         out_ff.air_speed <= root_ff[15:0];
         out_ff.energy_sum <= energy_ff[31:16];
         out_ff.drift_reset <= drift_ff;
      end
   end

endmodule
`default_nettype wire

/* hdl/dri_checker.sv */
// port level checks for the dead reckoning integrator, bound to the top level
`default_nettype none
module dri_port_checks (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire dri_pkg::req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire dri_pkg::rsp_type rsp_data
);

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a tick transfer keeps the block busy next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.operation |=> req_stall)
      else $error("tick transfer did not start work");

   // a fix transfer leaves the block ready
   a_fix_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation |=> !req_stall)
      else $error("fix transfer stalled input");

   // a new result only follows a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without preceding work");

endmodule

bind dead_reckoning_integrator_unit dri_port_checks u_checker (.*);
`default_nettype wire

/* verif/dri_checker.sv */
// transfer monitor, reference predictor and scoreboard for the dead reckoning integrator
`timescale 1ns / 100ps
module dri_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire dri_pkg::req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire dri_pkg::rsp_type rsp_data,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data,
   output int fail_count,
   output int waiting,
   output int result_count,
   output int drift_count
);

   logic signed [15:0] accel_gain, location_gain, filter_gain;
   logic [15:0] inverse_tau;
   logic [14:0] correction_period;

   logic signed [31:0] vel_sum [3];
   logic signed [31:0] loc_sum [3];
   logic signed [15:0] loc_err [3];
   logic signed [15:0] vel_err [3];
   logic signed [15:0] fix_loc [3];
   logic signed [15:0] fix_vel [3];
   logic [15:0] countdown;
   logic fix_pending;

   dri_pkg::rsp_type expected_rsp [$];

   function automatic shortint high_word(logic [31:0] v);
      return shortint'(v[31:16]);
   endfunction

   function automatic logic [15:0] floor_root(logic [31:0] n);
      logic [31:0] res, b;
      res = 0;
      b = 32'h4000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[15:0];
   endfunction

   // advances the filter by one tick and builds the result it reports
   function automatic dri_pkg::rsp_type integrate(dri_pkg::req_type r);
      dri_pkg::rsp_type o;
      logic signed [31:0] vel [3];
      logic signed [15:0] accel [3], wind [3], air [3];
      logic [31:0] sumsq, energy, acc;
      shortint w, h, nvx;
      longint wide;
      logic drift;
      accel = '{r.first_x, r.first_y, r.first_z};
      wind = '{r.second_x, r.second_y, r.second_z};
      drift = 1'b0;
      if (r.enabled) begin
         for (int k = 0; k < 3; k++) begin
            vel_sum[k] = vel_sum[k] + int'(accel_gain) * int'(accel[k]);
            loc_sum[k] = loc_sum[k] +
                         ((int'(location_gain) * int'(high_word(vel_sum[k]))) >>> 4);
         end
         if (countdown > 0) begin
            countdown = countdown - 1;
            for (int k = 0; k < 2; k++) begin
               vel_sum[k] = vel_sum[k] + int'(filter_gain) * int'(vel_err[k]);
               loc_sum[k] = loc_sum[k] + int'(filter_gain) * int'(loc_err[k]);
               // location error in cm wraps to 16 bits before the unsigned gain
               w = shortint'(16'(100 * int'(loc_err[k])));
               wide = longint'(inverse_tau) * longint'(w);
               vel[k] = vel_sum[k] + 32'(wide);
            end
            vel[2] = vel_sum[2];
         end else begin
            drift = 1'b1;
            for (int k = 0; k < 3; k++) vel[k] = vel_sum[k];
         end
         if (r.gps_valid && fix_pending) begin
            fix_pending = 1'b0;
            countdown = 16'(correction_period);
            for (int k = 0; k < 3; k++) begin
               loc_err[k] = 16'(int'(fix_loc[k]) - int'(high_word(loc_sum[k])));
               vel_err[k] = 16'(int'(fix_vel[k]) - int'(high_word(vel_sum[k])));
            end
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            vel_sum[k] = 0;
            loc_sum[k] = 0;
            vel[k] = 0;
         end
      end
      for (int k = 0; k < 3; k++) air[k] = 16'(int'(high_word(vel[k])) - int'(wind[k]));
      nvx = shortint'(16'(-int'(high_word(vel_sum[0]))));
      acc = 32'(int'(nvx) * int'(r.heading_a)) +
            32'(int'(high_word(vel_sum[1])) * int'(r.heading_b));
      acc = acc << 2;
      sumsq = 0;
      energy = 0;
      for (int k = 0; k < 3; k++) begin
         sumsq = sumsq + 32'(int'(air[k]) * int'(air[k]));
         h = high_word(32'(int'(air[k]) * 37877));
         energy = energy + 32'(int'(h) * int'(h));
      end
      energy = energy + loc_sum[2];
      o.velocity_x = high_word(vel[0]);
      o.velocity_y = high_word(vel[1]);
      o.velocity_z = high_word(vel[2]);
      o.location_x = high_word(loc_sum[0]);
      o.location_y = high_word(loc_sum[1]);
      o.location_z = high_word(loc_sum[2]);
      o.forward_speed = high_word(acc);
      o.air_speed = floor_root(sumsq);
      o.energy_sum = high_word(energy);
      o.drift_reset = drift;
      return o;
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      dri_pkg::rsp_type e;
      if (reset) begin
         accel_gain = dri_pkg::ACCEL_GAIN_RESET;
         location_gain = dri_pkg::LOCATION_GAIN_RESET;
         filter_gain = dri_pkg::FILTER_GAIN_RESET;
         inverse_tau = dri_pkg::INVERSE_TAU_RESET;
         correction_period = dri_pkg::CORRECTION_PERIOD_RESET;
         for (int k = 0; k < 3; k++) begin
            vel_sum[k] = 0; loc_sum[k] = 0; loc_err[k] = 0;
            vel_err[k] = 0; fix_loc[k] = 0; fix_vel[k] = 0;
         end
         countdown = 16'(dri_pkg::CORRECTION_PERIOD_RESET);
         fix_pending = 1'b0;
         expected_rsp.delete();
      end else begin
         if (csr_write) begin
            case (dri_pkg::csr_index_type'(csr_index))
               dri_pkg::CSR_ACCEL_GAIN: accel_gain = csr_data;
               dri_pkg::CSR_LOCATION_GAIN: location_gain = csr_data;
               dri_pkg::CSR_FILTER_GAIN: filter_gain = csr_data;
               dri_pkg::CSR_INVERSE_TAU: inverse_tau = csr_data;
               dri_pkg::CSR_CORRECTION_PERIOD: correction_period = csr_data[14:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_rsp.size() == 0) begin
               $error("result transfer with no expectation waiting");
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("velocity_x", e.velocity_x, rsp_data.velocity_x);
               check_field("velocity_y", e.velocity_y, rsp_data.velocity_y);
               check_field("velocity_z", e.velocity_z, rsp_data.velocity_z);
               check_field("location_x", e.location_x, rsp_data.location_x);
               check_field("location_y", e.location_y, rsp_data.location_y);
               check_field("location_z", e.location_z, rsp_data.location_z);
               check_field("forward_speed", e.forward_speed, rsp_data.forward_speed);
               check_field("air_speed", e.air_speed, rsp_data.air_speed);
               check_field("energy_sum", e.energy_sum, rsp_data.energy_sum);
               check_field("drift_reset", e.drift_reset, rsp_data.drift_reset);
               if (e.drift_reset) drift_count++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.operation) begin
               // gps fix: store only, no result
               fix_loc = '{req_data.first_x, req_data.first_y, req_data.first_z};
               fix_vel = '{req_data.second_x, req_data.second_y, req_data.second_z};
               fix_pending = 1'b1;
            end else begin
               expected_rsp.push_back(integrate(req_data));
            end
         end
      end
      waiting <= expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      waiting = 0;
      result_count = 0;
      drift_count = 0;
   end

endmodule

/* verif/tb.sv */
// testbench top: clock, reset, stimulus and verdict for the dead reckoning integrator
`timescale 1ns / 100ps
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dri_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dri_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   int fail_count, waiting, result_count, drift_count;
   int cycle_count = 0;
   int item_count = 0;
   bit no_idle = 1'b0;      // stretch with no gaps on either side
   bit long_hold = 1'b0;    // receiver holds off for a long stretch
   localparam int CYCLE_LIMIT = 1_000_000;

   always #5 clock = ~clock;

   dead_reckoning_integrator_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   dri_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .waiting(waiting),
      .result_count(result_count), .drift_count(drift_count)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random stall before each transfer, plus one long hold-off
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // one input transfer; valid stays high when no gap follows
   task automatic send(dri_pkg::req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      item_count++;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (waiting == 0);
      // a trailing fix gives no result
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(dri_pkg::csr_index_type idx, logic [15:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         4, 5: return 16'($signed(16'($urandom_range(0, 2047))) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic dri_pkg::req_type make_tick(bit en, bit gv);
      dri_pkg::req_type r;
      r.operation = 1'b0;
      r.enabled = en;
      r.gps_valid = gv;
      r.first_x = pick16(); r.first_y = pick16(); r.first_z = pick16();
      r.second_x = pick16(); r.second_y = pick16(); r.second_z = pick16();
      r.heading_a = pick16(); r.heading_b = pick16();
      return r;
   endfunction

   function automatic dri_pkg::req_type make_fix();
      dri_pkg::req_type r;
      r = make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      r.operation = 1'b1;
      return r;
   endfunction

   function automatic dri_pkg::req_type fill_tick(logic [15:0] v, bit en, bit gv);
      dri_pkg::req_type r;
      r.operation = 1'b0;
      r.enabled = en;
      r.gps_valid = gv;
      {r.first_x, r.first_y, r.first_z, r.second_x, r.second_y, r.second_z,
       r.heading_a, r.heading_b} = {8{v}};
      return r;
   endfunction

   // mostly enabled ticks with fixes every few ticks, so corrections keep latching
   task automatic random_phase(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) no_idle = ~no_idle;
         roll = $urandom_range(0, 99);
         if (roll < 15) send(make_fix());
         else if (roll < 20) send(make_tick(1'b0, 1'($urandom_range(0, 1))));
         else send(make_tick(1'b1, $urandom_range(0, 3) != 0));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      dri_pkg::req_type r;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: extremes, disabled tick, fix then latch, countdown expiry
      send(fill_tick(16'h7fff, 1'b1, 1'b0));
      send(fill_tick(16'h8000, 1'b1, 1'b1));
      send(fill_tick(16'hffff, 1'b1, 1'b0));
      send(fill_tick(16'h0000, 1'b0, 1'b1));
      r = fill_tick(16'h8000, 1'b0, 1'b0);
      r.operation = 1'b1;
      send(r);
      send(fill_tick(16'h1234, 1'b1, 1'b0));
      send(fill_tick(16'h0100, 1'b1, 1'b1));
      for (int i = 0; i < 16; i++) send(fill_tick(16'h0040, 1'b1, 1'b0));
      drain();

      // default gains
      random_phase(300);
      // fill the block while the receiver holds off
      long_hold = 1'b1;
      random_phase(40);
      // sender pauses until every result is back
      drain();

      write_reg(dri_pkg::CSR_ACCEL_GAIN, 16'h7fff);
      write_reg(dri_pkg::CSR_LOCATION_GAIN, 16'h7fff);
      write_reg(dri_pkg::CSR_FILTER_GAIN, 16'h7fff);
      write_reg(dri_pkg::CSR_INVERSE_TAU, 16'hffff);
      write_reg(dri_pkg::CSR_CORRECTION_PERIOD, 16'h7fff);
      random_phase(300);
      drain();

      write_reg(dri_pkg::CSR_ACCEL_GAIN, 16'h8000);
      write_reg(dri_pkg::CSR_LOCATION_GAIN, 16'h8000);
      write_reg(dri_pkg::CSR_FILTER_GAIN, 16'h8000);
      write_reg(dri_pkg::CSR_INVERSE_TAU, 16'h0000);
      write_reg(dri_pkg::CSR_CORRECTION_PERIOD, 16'h0000);
      random_phase(300);
      drain();

      for (int p = 0; p < 3; p++) begin
         write_reg(dri_pkg::CSR_ACCEL_GAIN, 16'($urandom));
         write_reg(dri_pkg::CSR_LOCATION_GAIN, 16'($urandom));
         write_reg(dri_pkg::CSR_FILTER_GAIN, 16'($urandom));
         write_reg(dri_pkg::CSR_INVERSE_TAU, 16'($urandom));
         write_reg(dri_pkg::CSR_CORRECTION_PERIOD, 16'($urandom_range(0, 40)));
         random_phase(350);
         drain();
      end

      $display("covered %0d input transfers, %0d results checked, %0d drift requests",
               item_count, result_count, drift_count);
      $display("six register settings incl. gain extremes, long receiver hold-off");
      if (fail_count == 0 && waiting == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
